// File: rtl/robin_hood_hash_table_defines.svh
// assertion macros for the robin hood hash table checker
// expects clk and rst_n in the scope where a macro is used
`ifndef ROBIN_HOOD_HASH_TABLE_DEFINES_SVH
`define ROBIN_HOOD_HASH_TABLE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RHH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RHH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rhh_pkg.sv
// shared types and constants of the robin hood hash table
// no dependencies
package rhh_pkg;

  localparam int CMD_W    = 3;
  localparam int HASH_W   = 48;
  localparam int POS_W    = 10;
  localparam int FILL_W   = 10;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;

  localparam logic [FILL_W-1:0] MAX_FILL_RESET = 10'd614;

  localparam logic [CMD_W-1:0] CMD_SET    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PROBE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_FOUND    = 3'd2,
    ST_NONE     = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_SRD, S_SEV, S_FRD, S_FEV, S_DRD, S_DEV, S_CLR, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_CAPTURE, OP_READ, OP_SET_EVAL, OP_FIND_EVAL, OP_SHIFT_EVAL,
    OP_CLEAR_STEP, OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_t;

  typedef struct packed {
    logic             empty;
    logic             match;
    logic             dib_le1;
    logic             full;
    logic             clr_last;
    logic             out_free;
    logic [CMD_W-1:0] cmd;
  } sts_t;

endpackage

// File: rtl/rhh_if.sv
// valid/ready channel interfaces: request, result and configuration
// depends on rhh_pkg
interface rhh_req_if #(parameter int KEY_BITS = 32, parameter int VALUE_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic [rhh_pkg::CMD_W-1:0]    command;
  logic [rhh_pkg::HASH_W-1:0]   hash;
  logic [KEY_BITS-1:0]          key;
  logic [VALUE_BITS-1:0]        value;
  logic [rhh_pkg::POS_W-1:0]    position;
  modport source (output valid, command, hash, key, value, position, input ready);
  modport sink (input valid, command, hash, key, value, position, output ready);
endinterface

interface rhh_res_if #(parameter int KEY_BITS = 32, parameter int VALUE_BITS = 32);
  logic                          valid;
  logic                          ready;
  logic [rhh_pkg::STATUS_W-1:0]  status;
  logic [KEY_BITS-1:0]           out_key;
  logic [VALUE_BITS-1:0]         out_value;
  logic [rhh_pkg::COUNT_W-1:0]   entry_count;
  modport source (output valid, status, out_key, out_value, entry_count, input ready);
  modport sink (input valid, status, out_key, out_value, entry_count, output ready);
endinterface

interface rhh_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rhh_pkg::FILL_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/rhh_dp.sv
// datapath: slot memory, probe registers, count, fill limit and result register
// depends on rhh_pkg; driven by rhh_ctrl
module rhh_dp #(
  parameter int SLOTS      = 1024,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rhh_pkg::ctl_t                 ctl,
  output rhh_pkg::sts_t                 sts,
  input  logic [rhh_pkg::CMD_W-1:0]     in_command,
  input  logic [rhh_pkg::HASH_W-1:0]    in_hash,
  input  logic [KEY_BITS-1:0]           in_key,
  input  logic [VALUE_BITS-1:0]         in_value,
  input  logic [rhh_pkg::POS_W-1:0]     in_position,
  input  logic                          cfg_valid,
  input  logic [rhh_pkg::FILL_W-1:0]    cfg_data,
  output logic                          out_valid,
  output logic [rhh_pkg::STATUS_W-1:0]  out_status,
  output logic [KEY_BITS-1:0]           out_key,
  output logic [VALUE_BITS-1:0]         out_value,
  output logic [rhh_pkg::COUNT_W-1:0]   out_entry_count,
  input  logic                          out_ready
);

  localparam int AW = $clog2(SLOTS);
  localparam int DW = AW + 1;
  localparam int CW = AW + 1;

  typedef struct packed {
    logic [DW-1:0]              dib;
    logic [rhh_pkg::HASH_W-1:0] hash;
    logic [KEY_BITS-1:0]        key;
    logic [VALUE_BITS-1:0]      val;
  } ent_t;

  ent_t mem [SLOTS];

  ent_t                           rd_q;
  ent_t                           cur_r;
  logic [AW-1:0]                  i_r;
  logic [AW-1:0]                  s_r;
  logic [rhh_pkg::CMD_W-1:0]      cmd_r;
  logic [CW-1:0]                  count_r;
  logic [rhh_pkg::FILL_W-1:0]     max_fill_r;
  rhh_pkg::status_t               res_status_r;
  logic [KEY_BITS-1:0]            res_key_r;
  logic [VALUE_BITS-1:0]          res_val_r;
  logic                           out_valid_r;
  logic [rhh_pkg::STATUS_W-1:0]   out_status_r;
  logic [KEY_BITS-1:0]            out_key_r;
  logic [VALUE_BITS-1:0]          out_value_r;
  logic [rhh_pkg::COUNT_W-1:0]    out_count_r;

  logic    empty, match, poorer, dib_le1, full;
  logic    we;
  logic [AW-1:0] wa;
  ent_t    wd;
  ent_t    shifted;

  assign empty   = (rd_q.dib == '0);
  assign match   = (rd_q.hash == cur_r.hash) && (rd_q.key == cur_r.key);
  assign poorer  = (rd_q.dib < cur_r.dib);
  assign dib_le1 = (rd_q.dib <= DW'(1));
  assign full    = (32'(count_r) >= 32'(max_fill_r)) || (count_r >= CW'(SLOTS - 1));

  always_comb begin
    shifted     = rd_q;
    shifted.dib = rd_q.dib - DW'(1);
  end

  assign sts.empty    = empty;
  assign sts.match    = match;
  assign sts.dib_le1  = dib_le1;
  assign sts.full     = full;
  assign sts.clr_last = (i_r == AW'(SLOTS - 1));
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.cmd      = cmd_r;

  // single write port
  always_comb begin
    we = 1'b0;
    wa = i_r;
    wd = cur_r;
    unique case (ctl.op)
      rhh_pkg::OP_SET_EVAL: begin
        if (empty || poorer) begin
          we = 1'b1;
        end else if (match) begin
          we     = 1'b1;
          wd     = rd_q;
          wd.val = cur_r.val;
        end
      end
      rhh_pkg::OP_SHIFT_EVAL: begin
        we = 1'b1;
        wa = s_r;
        wd = dib_le1 ? '0 : shifted;
      end
      rhh_pkg::OP_CLEAR_STEP: begin
        we = 1'b1;
        wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctl.op == rhh_pkg::OP_READ) begin
      rd_q <= mem[i_r];
    end
  end

  // probe walk, count and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r        <= '0;
      count_r    <= '0;
      max_fill_r <= rhh_pkg::MAX_FILL_RESET;
    end else begin
      if (cfg_valid) begin
        max_fill_r <= cfg_data;
      end
      unique case (ctl.op)
        rhh_pkg::OP_CAPTURE: begin
          cmd_r       <= in_command;
          cur_r.dib   <= DW'(1);
          cur_r.hash  <= in_hash;
          cur_r.key   <= in_key;
          cur_r.val   <= in_value;
          res_val_r   <= '0;
          if (in_command == rhh_pkg::CMD_PROBE) begin
            i_r <= AW'(in_position);
          end else if (in_command == rhh_pkg::CMD_CLEAR) begin
            i_r <= '0;
          end else begin
            i_r <= in_hash[AW-1:0];
          end
          if (in_command == rhh_pkg::CMD_SET && !full) begin
            res_status_r <= rhh_pkg::ST_INSERTED;
            res_key_r    <= in_key;
          end else begin
            res_status_r <= (in_command == rhh_pkg::CMD_SET) ? rhh_pkg::ST_FULL
                                                             : rhh_pkg::ST_NONE;
            res_key_r    <= '0;
          end
        end
        rhh_pkg::OP_SET_EVAL: begin
          if (empty) begin
            count_r <= count_r + CW'(1);
          end else if (match) begin
            res_status_r <= rhh_pkg::ST_REPLACED;
            res_key_r    <= rd_q.key;
            res_val_r    <= rd_q.val;
          end else begin
            i_r <= i_r + AW'(1);
            // displaced entry carries on down the chain
            if (poorer) begin
              cur_r <= '{dib: rd_q.dib + DW'(1), hash: rd_q.hash,
                         key: rd_q.key, val: rd_q.val};
            end else begin
              cur_r.dib <= cur_r.dib + DW'(1);
            end
          end
        end
        rhh_pkg::OP_FIND_EVAL: begin
          if (cmd_r == rhh_pkg::CMD_PROBE) begin
            if (!empty) begin
              res_status_r <= rhh_pkg::ST_FOUND;
              res_key_r    <= rd_q.key;
              res_val_r    <= rd_q.val;
            end
          end else if (!empty) begin
            if (match) begin
              res_status_r <= rhh_pkg::ST_FOUND;
              res_key_r    <= rd_q.key;
              res_val_r    <= rd_q.val;
              if (cmd_r == rhh_pkg::CMD_DELETE) begin
                s_r <= i_r;
                i_r <= i_r + AW'(1);
                if (count_r != '0) begin
                  count_r <= count_r - CW'(1);
                end
              end
            end else begin
              i_r <= i_r + AW'(1);
            end
          end
        end
        rhh_pkg::OP_SHIFT_EVAL: begin
          if (!dib_le1) begin
            s_r <= i_r;
            i_r <= i_r + AW'(1);
          end
        end
        rhh_pkg::OP_CLEAR_STEP: begin
          i_r          <= i_r + AW'(1);
          count_r      <= '0;
          res_status_r <= rhh_pkg::ST_CLEARED;
        end
        default: ;
      endcase
    end
  end

  // output register parts the result side from the walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.op == rhh_pkg::OP_PUSH) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == rhh_pkg::OP_PUSH) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_value_r  <= res_val_r;
      out_count_r  <= rhh_pkg::COUNT_W'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_key         = out_key_r;
  assign out_value       = out_value_r;
  assign out_entry_count = out_count_r;

endmodule

// File: rtl/rhh_ctrl.sv
// controller state machine: sequences reads and evaluations of the datapath
// depends on rhh_pkg; commands rhh_dp through ctl_t, reads sts_t
module rhh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rhh_pkg::sts_t sts,
  output rhh_pkg::ctl_t ctl
);

  rhh_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rhh_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl.op    = rhh_pkg::OP_NOP;
    in_ready  = 1'b0;
    unique case (state_r)
      rhh_pkg::S_INIT: begin
        ctl.op = rhh_pkg::OP_CLEAR_STEP;
        if (sts.clr_last) state_nxt = rhh_pkg::S_IDLE;
      end
      rhh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.op    = rhh_pkg::OP_CAPTURE;
          state_nxt = rhh_pkg::S_DISP;
        end
      end
      rhh_pkg::S_DISP: begin
        unique case (sts.cmd)
          rhh_pkg::CMD_SET:    state_nxt = sts.full ? rhh_pkg::S_OUT : rhh_pkg::S_SRD;
          rhh_pkg::CMD_GET,
          rhh_pkg::CMD_DELETE,
          rhh_pkg::CMD_PROBE:  state_nxt = rhh_pkg::S_FRD;
          rhh_pkg::CMD_CLEAR:  state_nxt = rhh_pkg::S_CLR;
          default:             state_nxt = rhh_pkg::S_OUT;
        endcase
      end
      rhh_pkg::S_SRD: begin
        ctl.op    = rhh_pkg::OP_READ;
        state_nxt = rhh_pkg::S_SEV;
      end
      rhh_pkg::S_SEV: begin
        ctl.op    = rhh_pkg::OP_SET_EVAL;
        state_nxt = (sts.empty || sts.match) ? rhh_pkg::S_OUT : rhh_pkg::S_SRD;
      end
      rhh_pkg::S_FRD: begin
        ctl.op    = rhh_pkg::OP_READ;
        state_nxt = rhh_pkg::S_FEV;
      end
      rhh_pkg::S_FEV: begin
        ctl.op = rhh_pkg::OP_FIND_EVAL;
        priority if (sts.cmd == rhh_pkg::CMD_PROBE || sts.empty) begin
          state_nxt = rhh_pkg::S_OUT;
        end else if (sts.match) begin
          state_nxt = (sts.cmd == rhh_pkg::CMD_DELETE) ? rhh_pkg::S_DRD : rhh_pkg::S_OUT;
        end else begin
          state_nxt = rhh_pkg::S_FRD;
        end
      end
      rhh_pkg::S_DRD: begin
        ctl.op    = rhh_pkg::OP_READ;
        state_nxt = rhh_pkg::S_DEV;
      end
      rhh_pkg::S_DEV: begin
        ctl.op    = rhh_pkg::OP_SHIFT_EVAL;
        state_nxt = sts.dib_le1 ? rhh_pkg::S_OUT : rhh_pkg::S_DRD;
      end
      rhh_pkg::S_CLR: begin
        ctl.op = rhh_pkg::OP_CLEAR_STEP;
        if (sts.clr_last) state_nxt = rhh_pkg::S_OUT;
      end
      rhh_pkg::S_OUT: begin
        if (sts.out_free) begin
          ctl.op    = rhh_pkg::OP_PUSH;
          state_nxt = rhh_pkg::S_IDLE;
        end
      end
      default: state_nxt = rhh_pkg::S_INIT;
    endcase
  end

endmodule

// File: rtl/robin_hood_hash_table.sv
// top level of the robin hood hash table: controller plus datapath
// depends on rhh_pkg, rhh_if, rhh_ctrl, rhh_dp
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    command, hash, key, value, position
//  out_ch   out  valid/ready    status, out_key, out_value, entry_count
//  cfg_ch   in   valid/ready    data (max_fill), ready always high
//
// one request at a time; set, get and delete visit each slot in the probe chain
// with one memory read and one evaluate, delete also reads and evaluates each slot
// behind the removed entry (each entry shifted back and the slot ending
// the chain), and every request passes capture, dispatch and result transfer.
// clear writes every slot through the memory write port.
// after reset a clearing pass over every slot runs before the first transfer.
// a result waiting in the output register holds only the next result back.
module robin_hood_hash_table #(
  parameter int SLOTS      = 1024,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input logic clk,
  input logic rst_n,
  rhh_req_if.sink   in_ch,
  rhh_res_if.source out_ch,
  rhh_cfg_if.sink   cfg_ch
);

  rhh_pkg::ctl_t ctl;
  rhh_pkg::sts_t sts;

  assign cfg_ch.ready = 1'b1;

  rhh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  rhh_dp #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_command      (in_ch.command),
    .in_hash         (in_ch.hash),
    .in_key          (in_ch.key),
    .in_value        (in_ch.value),
    .in_position     (in_ch.position),
    .cfg_valid       (cfg_ch.valid),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_key         (out_ch.out_key),
    .out_value       (out_ch.out_value),
    .out_entry_count (out_ch.entry_count),
    .out_ready       (out_ch.ready)
  );

endmodule

// File: rtl/rhh_checker.sv
// port-level checker for the robin hood hash table, bound to the top level
// depends on rhh_pkg and robin_hood_hash_table_defines.svh
`include "robin_hood_hash_table_defines.svh"

module rhh_checker #(
  parameter int SLOTS      = 1024,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rhh_pkg::STATUS_W-1:0]  status,
  input logic [KEY_BITS-1:0]           out_key,
  input logic [VALUE_BITS-1:0]         out_value,
  input logic [rhh_pkg::COUNT_W-1:0]   entry_count
);

  logic out_stall;
  logic cleared;
  logic no_entry;

  assign out_stall = out_valid && !out_ready;
  assign cleared   = out_valid && status == rhh_pkg::ST_CLEARED;
  assign no_entry  = out_valid && (status == rhh_pkg::ST_NONE || status == rhh_pkg::ST_FULL);

  // one request in flight: ready drops after every input transfer
  `RHH_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "ready after transfer")

  `RHH_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(status), "result dropped")

  `RHH_ASSERT_NOW(a_count_bound, out_valid, 32'(entry_count) <= 32'(SLOTS - 1), "count too large")

  `RHH_ASSERT_NOW(a_clear_zero, cleared, entry_count == '0, "clear left entries")

  // no entry behind a miss or a refusal
  `RHH_ASSERT_NOW(a_none_zero, no_entry, out_key == '0 && out_value == '0, "stale payload")

endmodule

bind robin_hood_hash_table rhh_checker #(
  .SLOTS      (SLOTS),
  .KEY_BITS   (KEY_BITS),
  .VALUE_BITS (VALUE_BITS)
) u_rhh_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .out_key     (out_ch.out_key),
  .out_value   (out_ch.out_value),
  .entry_count (out_ch.entry_count)
);

// File: dv/robin_hood_hash_table_test.sv
// testbench for the robin hood hash table: directed and random requests,
// a local model of the table predicts every result
// depends on rhh_pkg, rhh_if and robin_hood_hash_table
module robin_hood_hash_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 1024;
  localparam int IDLE_LIMIT = 10000;
  localparam int LONG_STALL_CYCLES = 600;
  // command codes outside the defined set
  localparam logic [rhh_pkg::CMD_W-1:0] CMD_UNDEF_LO = 3'd5;
  localparam logic [rhh_pkg::CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [rhh_pkg::CMD_W-1:0]  command;
    logic [rhh_pkg::HASH_W-1:0] hash;
    logic [31:0]                key;
    logic [31:0]                value;
    logic [rhh_pkg::POS_W-1:0]  position;
  } request_t;

  typedef struct packed {
    rhh_pkg::status_t            status;
    logic [31:0]                 key;
    logic [31:0]                 value;
    logic [rhh_pkg::COUNT_W-1:0] count;
  } answer_t;

  logic clk = 0;
  logic rst_n = 0;
  always #4 clk = ~clk;

  rhh_req_if in_ch ();
  rhh_res_if out_ch ();
  rhh_cfg_if cfg_ch ();

  robin_hood_hash_table DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // table model
  logic [rhh_pkg::HASH_W-1:0] tbl_hash [SLOTS];
  int unsigned                tbl_dib [SLOTS];
  logic [31:0]                tbl_key [SLOTS];
  logic [31:0]                tbl_val [SLOTS];
  int unsigned                tbl_count;
  int unsigned                fill_limit;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int errors = 0, sent = 0, received = 0, idle_cycles = 0;
  int n_inserted = 0, n_full = 0, n_found = 0;
  bit hold_sender = 0;

  function automatic bit lookup(logic [rhh_pkg::HASH_W-1:0] h, logic [31:0] k,
                                output int where);
    int i;
    i = int'(h % SLOTS);
    for (int n = 0; n < SLOTS; n++) begin
      if (tbl_dib[i] == 0) return 0;
      if (tbl_hash[i] == h && tbl_key[i] == k) begin
        where = i;
        return 1;
      end
      i = (i + 1) % SLOTS;
    end
    return 0;
  endfunction

  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int s, i, nx, cd, td;
    logic [rhh_pkg::HASH_W-1:0] ch, th;
    logic [31:0] ck, cv, tk, tv;
    a = '{rhh_pkg::ST_NONE, 32'd0, 32'd0, 11'd0};
    case (r.command)
      rhh_pkg::CMD_SET: begin
        if (tbl_count >= fill_limit || tbl_count >= SLOTS - 1) a.status = rhh_pkg::ST_FULL;
        else begin
          a.status = rhh_pkg::ST_INSERTED;
          a.key = r.key;
          ch = r.hash; ck = r.key; cv = r.value; cd = 1;
          i = int'(r.hash % SLOTS);
          for (int n = 0; n < SLOTS; n++) begin
            if (tbl_dib[i] == 0) begin
              tbl_hash[i] = ch; tbl_key[i] = ck; tbl_val[i] = cv; tbl_dib[i] = cd;
              tbl_count++;
              break;
            end
            if (tbl_hash[i] == ch && tbl_key[i] == ck) begin
              a.key = tbl_key[i];
              a.value = tbl_val[i];
              tbl_val[i] = cv;
              a.status = rhh_pkg::ST_REPLACED;
              break;
            end
            if (tbl_dib[i] < cd) begin
              th = tbl_hash[i]; tk = tbl_key[i]; tv = tbl_val[i]; td = tbl_dib[i];
              tbl_hash[i] = ch; tbl_key[i] = ck; tbl_val[i] = cv; tbl_dib[i] = cd;
              ch = th; ck = tk; cv = tv; cd = td;
            end
            i = (i + 1) % SLOTS;
            cd++;
          end
        end
      end
      rhh_pkg::CMD_GET: if (lookup(r.hash, r.key, s)) begin
        a.status = rhh_pkg::ST_FOUND; a.key = tbl_key[s]; a.value = tbl_val[s];
      end
      rhh_pkg::CMD_DELETE: if (lookup(r.hash, r.key, s)) begin
        a.status = rhh_pkg::ST_FOUND; a.key = tbl_key[s]; a.value = tbl_val[s];
        // backward shift of the chain behind the removed entry
        for (int n = 0; n < SLOTS; n++) begin
          nx = (s + 1) % SLOTS;
          if (tbl_dib[nx] <= 1) begin
            tbl_dib[s] = 0;
            break;
          end
          tbl_dib[s] = tbl_dib[nx] - 1;
          tbl_hash[s] = tbl_hash[nx]; tbl_key[s] = tbl_key[nx]; tbl_val[s] = tbl_val[nx];
          s = nx;
        end
        if (tbl_count > 0) tbl_count--;
      end
      rhh_pkg::CMD_PROBE: if (tbl_dib[r.position % SLOTS] != 0) begin
        a.status = rhh_pkg::ST_FOUND;
        a.key = tbl_key[r.position % SLOTS];
        a.value = tbl_val[r.position % SLOTS];
      end
      rhh_pkg::CMD_CLEAR: begin
        for (int n = 0; n < SLOTS; n++) tbl_dib[n] = 0;
        tbl_count = 0;
        a.status = rhh_pkg::ST_CLEARED;
      end
      default: ;
    endcase
    a.count = tbl_count[rhh_pkg::COUNT_W-1:0];
    return a;
  endfunction

  // input transfer seen at the rising edge, consumed by the driver
  bit in_taken = 0;
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // hold the offered item
    end else begin
      if (in_taken) begin
        void'(pending_reqs.pop_front());
        sent++;
      end
      if (gap_left > 0) gap_left--;
      else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (pending_reqs.size() > 0 && !hold_sender && gap_left == 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.command, in_ch.hash, in_ch.key, in_ch.value, in_ch.position}
          <= pending_reqs[0];
        burst_left--;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // prediction at the transfer edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      expected_answers.push_back(apply_request({in_ch.command, in_ch.hash, in_ch.key,
                                                in_ch.value, in_ch.position}));
  end

  // receiver stall pattern, with one long hold-off counted here
  int stall_phase = 0;
  bit long_stall_req = 0;
  bit long_stall_done = 0;
  int long_left = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_left > 0) begin
      out_ch.ready <= 1'b0;
      long_left <= long_left - 1;
      if (long_left == 1) long_stall_done <= 1'b1;
    end else if (long_stall_req && !long_stall_done) begin
      out_ch.ready <= 1'b0;
      long_left <= LONG_STALL_CYCLES;
    end else if (stall_phase % 64 < 20) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // monitor
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      received++;
      if (expected_answers.size() == 0) begin
        $error("result transfer with no expectation, status %0d", out_ch.status);
        errors++;
      end else begin
        e = expected_answers.pop_front();
        if (out_ch.status != e.status) begin
          $error("status expected %0d actual %0d", e.status, out_ch.status); errors++;
        end
        if (out_ch.out_key != e.key) begin
          $error("out_key expected %h actual %h", e.key, out_ch.out_key); errors++;
        end
        if (out_ch.out_value != e.value) begin
          $error("out_value expected %h actual %h", e.value, out_ch.out_value); errors++;
        end
        if (out_ch.entry_count != e.count) begin
          $error("entry_count expected %0d actual %0d", e.count, out_ch.entry_count);
          errors++;
        end
        if (e.status == rhh_pkg::ST_INSERTED) n_inserted++;
        if (e.status == rhh_pkg::ST_FULL) n_full++;
        if (e.status == rhh_pkg::ST_FOUND) n_found++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || long_left > 0)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  // keys used so far, for hits on get, delete and replace
  logic [rhh_pkg::HASH_W-1:0] used_hash[$];
  logic [31:0]                used_key[$];

  task automatic add_item(logic [rhh_pkg::CMD_W-1:0] c, logic [rhh_pkg::HASH_W-1:0] h,
                          logic [31:0] k, logic [31:0] v, logic [rhh_pkg::POS_W-1:0] p);
    pending_reqs.push_back('{c, h, k, v, p});
    if (c == rhh_pkg::CMD_SET) begin
      used_hash.push_back(h);
      used_key.push_back(k);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_fill_limit(logic [rhh_pkg::FILL_W-1:0] lim);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= lim;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    fill_limit = lim;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(int count, int key_pool);
    int j;
    logic [rhh_pkg::HASH_W-1:0] h;
    logic [31:0] k, v;
    logic [rhh_pkg::POS_W-1:0] p;
    logic [rhh_pkg::CMD_W-1:0] c;
    for (int n = 0; n < count; n++) begin
      h = rhh_pkg::HASH_W'({$urandom, $urandom});
      k = $urandom;
      v = $urandom;
      p = rhh_pkg::POS_W'($urandom);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          // small home-slot spread so chains collide and shift
          if ($urandom_range(0, 1))
            h = rhh_pkg::HASH_W'({h[5], 5'd0}) + rhh_pkg::HASH_W'($urandom_range(0, 40));
          add_item(rhh_pkg::CMD_SET, h, $urandom_range(0, key_pool), v, p);
        end
        8, 9, 10, 11, 12: if (used_key.size() > 0) begin
          j = $urandom_range(0, used_key.size() - 1);
          add_item(rhh_pkg::CMD_GET, used_hash[j], used_key[j], v, p);
        end else add_item(rhh_pkg::CMD_GET, h, k, v, p);
        13, 14, 15: if (used_key.size() > 0) begin
          j = $urandom_range(0, used_key.size() - 1);
          add_item(rhh_pkg::CMD_DELETE, used_hash[j], used_key[j], v, p);
        end
        16: add_item(rhh_pkg::CMD_SET, used_key.size() ? used_hash[0] : 48'd0,
                     used_key.size() ? used_key[0] : 32'd0, v, p);
        17: add_item(rhh_pkg::CMD_PROBE, h, k, v, p);
        18: begin
          c = $urandom_range(0, 1) ? rhh_pkg::CMD_GET : rhh_pkg::CMD_DELETE;
          add_item(c, h, k, v, p);
        end
        default: begin
          if ($urandom_range(0, 40) == 0) c = rhh_pkg::CMD_CLEAR;
          else c = rhh_pkg::CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
          add_item(c, h, k, v, p);
        end
      endcase
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.command = '0; in_ch.hash = '0; in_ch.key = '0;
    in_ch.value = '0; in_ch.position = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    for (int n = 0; n < SLOTS; n++) tbl_dib[n] = 0;
    tbl_count = 0;
    fill_limit = rhh_pkg::MAX_FILL_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // directed: extremes, collisions, wraparound, each command
    add_item(rhh_pkg::CMD_GET, 48'd5, 32'd1, 32'd0, 10'd0);
    add_item(rhh_pkg::CMD_PROBE, 48'd0, 32'd0, 32'd0, 10'd1023);
    add_item(rhh_pkg::CMD_SET, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023);
    add_item(rhh_pkg::CMD_SET, 48'h3FF, 32'd0, 32'd0, 10'd0);
    add_item(rhh_pkg::CMD_SET, 48'h7FF, 32'd7, 32'd70, 10'd0);
    add_item(rhh_pkg::CMD_SET, 48'h0, 32'd9, 32'd90, 10'd0);
    add_item(rhh_pkg::CMD_SET, 48'h400, 32'd9, 32'd91, 10'd0);
    add_item(rhh_pkg::CMD_SET, 48'h7FF, 32'd7, 32'd71, 10'd0);
    add_item(rhh_pkg::CMD_PROBE, 48'd0, 32'd0, 32'd0, 10'd1023);
    add_item(rhh_pkg::CMD_PROBE, 48'd0, 32'd0, 32'd0, 10'd1);
    add_item(rhh_pkg::CMD_GET, 48'h400, 32'd9, 32'd0, 10'd0);
    add_item(rhh_pkg::CMD_GET, 48'h400, 32'd8, 32'd0, 10'd0);
    add_item(rhh_pkg::CMD_DELETE, 48'h3FF, 32'd0, 32'd0, 10'd0);
    add_item(rhh_pkg::CMD_PROBE, 48'd0, 32'd0, 32'd0, 10'd1023);
    add_item(rhh_pkg::CMD_DELETE, 48'h3FF, 32'd0, 32'd0, 10'd0);
    add_item(CMD_UNDEF_LO, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
    add_item(CMD_UNDEF_HI, 48'd0, 32'd0, 32'd0, 10'd0);
    add_item(rhh_pkg::CMD_CLEAR, 48'd0, 32'd0, 32'd0, 10'd0);
    add_item(rhh_pkg::CMD_GET, 48'h7FF, 32'd7, 32'd0, 10'd0);
    wait_drained();

    // low fill limit, then lowered below the count
    write_fill_limit(10'd1);
    add_item(rhh_pkg::CMD_SET, 48'd3, 32'd3, 32'd30, 10'd0);
    add_item(rhh_pkg::CMD_SET, 48'd3, 32'd3, 32'd31, 10'd0);
    add_item(rhh_pkg::CMD_SET, 48'd4, 32'd4, 32'd40, 10'd0);
    random_phase(40, 15);
    wait_drained();
    write_fill_limit(10'd0);
    add_item(rhh_pkg::CMD_SET, 48'd8, 32'd8, 32'd80, 10'd0);
    add_item(rhh_pkg::CMD_CLEAR, 48'd0, 32'd0, 32'd0, 10'd0);
    wait_drained();

    write_fill_limit(10'd12);
    random_phase(100, 20);

    // long receiver stall while requests keep coming
    long_stall_req = 1;
    wait (long_stall_done);
    long_stall_req = 0;
    wait_drained();

    // sender waits for everything outstanding, then resumes
    random_phase(40, 255);
    repeat (60) @(posedge clk);
    hold_sender = 1;
    while (in_ch.valid || expected_answers.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    hold_sender = 0;
    wait_drained();

    write_fill_limit(10'd1023);
    random_phase(180, 255);
    wait_drained();
    write_fill_limit(rhh_pkg::MAX_FILL_RESET);
    random_phase(60, 1000);
    wait_drained();

    $display("%0d requests sent, %0d results checked", sent, received);
    $display("inserted %0d, found %0d, refused as full %0d", n_inserted, n_found, n_full);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
